[design/moving_average_direction_detector_macros.svh]
// Assertion macros used by the checker file.
`ifndef MOVING_AVERAGE_DIRECTION_DETECTOR_MACROS_SVH
`define MOVING_AVERAGE_DIRECTION_DETECTOR_MACROS_SVH

// Concurrent assertion, masked while reset is asserted.
`define MADD_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Concurrent assertion that also holds during reset.
`define MADD_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) \
        else $error(msg);

`endif

[design/madd_pkg.sv]
package madd_pkg;

    localparam int WINDOW       = 10;
    localparam int SAMPLE_BITS  = 16;
    localparam int SLOT_BITS    = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int SUM_BITS     = SAMPLE_BITS + $clog2(WINDOW) + 1;
    localparam int THR_BITS     = 15;
    localparam int HOLD_BITS    = 8;
    localparam int CFG_IDX_BITS = 2;
    localparam int CFG_DATA_BITS = 16;
    localparam int SCALED_BITS  = THR_BITS + $clog2(WINDOW) + 1;
    localparam int CMP_BITS     = ((SUM_BITS > SCALED_BITS) ? SUM_BITS : SCALED_BITS) + 1;

    typedef logic signed [SAMPLE_BITS-1:0]   t_sample;
    typedef logic        [SLOT_BITS-1:0]     t_slot;
    typedef logic signed [SUM_BITS-1:0]      t_sum;
    typedef logic signed [CMP_BITS-1:0]      t_cmp;
    typedef logic        [THR_BITS-1:0]      t_threshold;
    typedef logic        [HOLD_BITS-1:0]     t_holdoff;
    typedef logic        [CFG_DATA_BITS-1:0] t_cfg_data;
    typedef logic signed [1:0]               t_direction;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_SPEED_THRESHOLD = 2'd0,
        REG_HOLDOFF_LIMIT   = 2'd1
    } t_cfg_reg;

    localparam t_direction DIR_STOP = 2'sd0;
    localparam t_direction DIR_FWD  = 2'sd1;
    localparam t_direction DIR_BWD  = -2'sd1;

    localparam t_slot      SLOT_LAST       = t_slot'(WINDOW - 1);
    localparam t_threshold THRESHOLD_RESET = t_threshold'(10);
    localparam t_holdoff   HOLDOFF_RESET   = t_holdoff'(10);
    localparam t_cmp       SCALED_RESET    = t_cmp'((10 + 1) * WINDOW);

endpackage

[design/madd_if.sv]
interface madd_in_if import madd_pkg::*; ();
    logic    valid;
    logic    ready;
    t_sample motor_speed;

    modport source (output valid, output motor_speed, input ready);
    modport sink   (input valid, input motor_speed, output ready);
endinterface

interface madd_out_if import madd_pkg::*; ();
    logic       valid;
    logic       ready;
    t_direction direction;

    modport source (output valid, output direction, input ready);
    modport sink   (input valid, input direction, output ready);
endinterface

interface madd_cfg_if import madd_pkg::*; ();
    logic      valid;
    logic      ready;
    t_cfg_reg  index;
    t_cfg_data data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

[design/moving_average_direction_detector.sv]
// Moving average direction detector.
// i_in carries one signed speed word per control period; o_out returns one
// direction word for each (1 forward, -1 backward, 0 stopped or held off).
// i_cfg writes speed_threshold (index 0) and holdoff_limit (index 1); other
// indexes are dropped. Write it only while no word is in flight.
// An accepted word passes the compare stage and then the output register,
// which it enters only when that register is free or being taken at o_out.
// Throughput is one word per cycle while the receiver does not stall.
// The sample ring sits in a small memory with a registered read: the old
// sample is read in the accept cycle, and the next stage subtracts it from
// the running sum, writes the new sample back and compares against
// (threshold + 1) times the window. Back-to-back writes and reads of the
// same slot are forwarded.
// Reset clears the ring (per-slot valid bits), the running sum, the slot
// pointer and the hold-off count, and loads both registers with 10; the first
// holdoff_limit words after reset read 0. No clearing pass is needed.
// When the receiver stalls, the output register holds its word, one more
// word waits in the compare stage, and i_in.ready drops until o_out moves.
module moving_average_direction_detector import madd_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    madd_in_if.sink    i_in,
    madd_out_if.source o_out,
    madd_cfg_if.sink   i_cfg
);

    t_sample    r_ring [WINDOW];
    logic       r_ring_vld [WINDOW];

    t_slot      r_slot;
    t_sum       r_sum;
    t_holdoff   r_hold_cnt;
    t_holdoff   r_holdoff_limit;
    t_cmp       r_thr_scaled;

    logic       r_s1_valid;
    t_sample    r_s1_sample;
    t_slot      r_s1_slot;
    t_sample    r_rd_data;
    logic       r_rd_vld;
    logic       r_fwd;
    t_sample    r_fwd_data;

    logic       r_out_valid;
    t_direction r_out_dir;

    logic       in_fire;
    logic       s1_fire;
    t_slot      n_slot;
    t_sample    old_sample;
    t_sum       n_sum;
    t_cmp       sum_ext;
    logic       is_fwd;
    logic       is_bwd;
    t_holdoff   hold_base;
    t_holdoff   n_hold_cnt;
    t_direction n_dir;

    assign s1_fire     = r_s1_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready  = !r_s1_valid || s1_fire;
    assign in_fire     = i_in.valid && i_in.ready;
    assign i_cfg.ready = 1'b1;

    assign o_out.valid     = r_out_valid;
    assign o_out.direction = r_out_dir;

    always_comb begin
        n_slot = (r_slot == SLOT_LAST) ? '0 : r_slot + t_slot'(1);
    end

    always_comb begin
        if (r_fwd) begin
            old_sample = r_fwd_data;
        end else if (r_rd_vld) begin
            old_sample = r_rd_data;
        end else begin
            old_sample = '0;
        end
        n_sum   = r_sum - t_sum'(old_sample) + t_sum'(r_s1_sample);
        sum_ext = t_cmp'(n_sum);
        is_fwd  = sum_ext >= r_thr_scaled;
        is_bwd  = sum_ext <= -r_thr_scaled;

        hold_base = (is_fwd || is_bwd) ? r_hold_cnt : '0;
        if (hold_base < r_holdoff_limit) begin
            n_hold_cnt = hold_base + t_holdoff'(1);
            n_dir      = DIR_STOP;
        end else begin
            n_hold_cnt = hold_base;
            if (is_fwd) begin
                n_dir = DIR_FWD;
            end else if (is_bwd) begin
                n_dir = DIR_BWD;
            end else begin
                n_dir = DIR_STOP;
            end
        end
    end

    // sample ring memory plus the unreset stage and output data registers
    always_ff @(posedge i_clk) begin
        if (s1_fire) begin
            r_ring[r_s1_slot] <= r_s1_sample;
        end
        if (in_fire) begin
            r_rd_data   <= r_ring[r_slot];
            r_rd_vld    <= r_ring_vld[r_slot];
            r_fwd_data  <= r_s1_sample;
            r_s1_sample <= i_in.motor_speed;
            r_s1_slot   <= r_slot;
        end
        if (s1_fire) begin
            r_out_dir <= n_dir;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < WINDOW; i++) begin
                r_ring_vld[i] <= 1'b0;
            end
            r_slot          <= '0;
            r_sum           <= '0;
            r_hold_cnt      <= '0;
            r_holdoff_limit <= HOLDOFF_RESET;
            r_thr_scaled    <= SCALED_RESET;
            r_s1_valid      <= 1'b0;
            r_fwd           <= 1'b0;
            r_out_valid     <= 1'b0;
        end else begin
            if (in_fire) begin
                r_slot     <= n_slot;
                r_fwd      <= s1_fire && (r_s1_slot == r_slot);
                r_s1_valid <= 1'b1;
            end else if (s1_fire) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_fire) begin
                r_ring_vld[r_s1_slot] <= 1'b1;
                r_sum                 <= n_sum;
                r_hold_cnt            <= n_hold_cnt;
                r_out_valid           <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg.valid) begin
                unique case (i_cfg.index)
                    REG_SPEED_THRESHOLD: begin
                        r_thr_scaled <= (t_cmp'(i_cfg.data[THR_BITS-1:0]) + t_cmp'(1))
                                        * t_cmp'(WINDOW);
                    end
                    REG_HOLDOFF_LIMIT: begin
                        r_holdoff_limit <= i_cfg.data[HOLD_BITS-1:0];
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

endmodule

[design/madd_checker.sv]
`include "moving_average_direction_detector_macros.svh"

module madd_checker import madd_pkg::*; (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       i_in_ready,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input t_direction i_out_direction
);

    `MADD_ASSERT(a_dir_code, i_clk, i_rst_n,
        i_out_valid |-> (i_out_direction != 2'b10), "direction code out of range")

    `MADD_ASSERT(a_ready_when_empty, i_clk, i_rst_n,
        !i_out_valid |-> i_in_ready, "input stalled with an empty output")

    `MADD_ASSERT(a_latency, i_clk, i_rst_n,
        (i_in_valid && i_in_ready) ##1 i_out_ready |=> i_out_valid,
        "result missing two cycles after accept")

    `MADD_ASSERT(a_out_hold, i_clk, i_rst_n,
        (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_out_direction)),
        "stalled output word changed")

endmodule

bind moving_average_direction_detector madd_checker u_madd_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_in_valid      (i_in.valid),
    .i_in_ready      (i_in.ready),
    .i_out_valid     (o_out.valid),
    .i_out_ready     (o_out.ready),
    .i_out_direction (o_out.direction)
);

[tb/madd_direction_checker.sv]
`timescale 1ns / 1ps

module madd_direction_checker import madd_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    madd_in_if   in_bus,
    madd_out_if  out_bus,
    madd_cfg_if  cfg_bus,
    output int   o_fail_count,
    output int   o_pending,
    output int   o_fwd_count,
    output int   o_bwd_count,
    output int   o_stop_count
);

    int         speed_ring [WINDOW];
    int         speed_sum;
    int         ring_slot;
    t_threshold threshold;
    t_holdoff   hold_limit;
    t_holdoff   hold_count;
    t_direction expected_dirs [$];

    function automatic t_direction predict_direction(t_sample speed);
        int         mean;
        t_direction dir;
        speed_sum = speed_sum - speed_ring[ring_slot] + int'(speed);
        speed_ring[ring_slot] = int'(speed);
        ring_slot = (ring_slot == WINDOW - 1) ? 0 : ring_slot + 1;
        mean = speed_sum / WINDOW;
        if (mean > int'(threshold)) begin
            dir = DIR_FWD;
        end else if (mean < -int'(threshold)) begin
            dir = DIR_BWD;
        end else begin
            dir = DIR_STOP;
            hold_count = '0;
        end
        // force stop while the hold-off count is below its limit
        if (hold_count < hold_limit) begin
            hold_count = hold_count + 1'b1;
            dir = DIR_STOP;
        end
        return dir;
    endfunction

    always @(posedge i_clk) begin
        t_direction want;
        if (!i_rst_n) begin
            foreach (speed_ring[k]) speed_ring[k] = 0;
            speed_sum    = 0;
            ring_slot    = 0;
            threshold    = THRESHOLD_RESET;
            hold_limit   = HOLDOFF_RESET;
            hold_count   = '0;
            expected_dirs.delete();
            o_fail_count = 0;
            o_fwd_count  = 0;
            o_bwd_count  = 0;
            o_stop_count = 0;
        end else begin
            if (cfg_bus.valid && cfg_bus.ready) begin
                case (cfg_bus.index)
                    REG_SPEED_THRESHOLD: threshold = cfg_bus.data[THR_BITS-1:0];
                    REG_HOLDOFF_LIMIT:   hold_limit = cfg_bus.data[HOLD_BITS-1:0];
                    default: ;
                endcase
            end
            if (in_bus.valid && in_bus.ready) begin
                expected_dirs.push_back(predict_direction(in_bus.motor_speed));
            end
            if (out_bus.valid && out_bus.ready) begin
                if (expected_dirs.size() == 0) begin
                    $display("%0t: direction expected none got %0d", $time,
                             out_bus.direction);
                    o_fail_count++;
                end else begin
                    want = expected_dirs.pop_front();
                    if (out_bus.direction !== want) begin
                        $display("%0t: direction expected %0d got %0d", $time,
                                 want, out_bus.direction);
                        o_fail_count++;
                    end
                    if (want == DIR_FWD) o_fwd_count++;
                    else if (want == DIR_BWD) o_bwd_count++;
                    else o_stop_count++;
                end
            end
        end
        o_pending = expected_dirs.size();
    end

endmodule

[tb/tb.sv]
`timescale 1ns / 1ps

module tb;
    import madd_pkg::*;

    localparam int       SPEED_MAX   = 32767;
    localparam int       SPEED_MIN   = -32768;
    localparam t_cfg_reg REG_SPARE_2 = t_cfg_reg'(2'd2);
    localparam t_cfg_reg REG_SPARE_3 = t_cfg_reg'(2'd3);

    logic i_clk = 1'b0;
    logic i_rst_n;

    int fail_count;
    int pending;
    int fwd_count;
    int bwd_count;
    int stop_count;

    int samples_sent;
    int reg_writes;
    int settings_run;
    int cur_threshold;
    bit gaps_on;

    madd_in_if  in_bus ();
    madd_out_if out_bus ();
    madd_cfg_if cfg_bus ();

    moving_average_direction_detector dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_bus),
        .o_out   (out_bus),
        .i_cfg   (cfg_bus)
    );

    madd_direction_checker direction_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .in_bus       (in_bus),
        .out_bus      (out_bus),
        .cfg_bus      (cfg_bus),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_fwd_count  (fwd_count),
        .o_bwd_count  (bwd_count),
        .o_stop_count (stop_count)
    );

    always #4 i_clk = ~i_clk;

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic t_sample clamp_speed(int v);
        if (v > SPEED_MAX) return t_sample'(SPEED_MAX);
        if (v < SPEED_MIN) return t_sample'(SPEED_MIN);
        return t_sample'(v);
    endfunction

    task automatic send_speed(t_sample speed);
        int gap;
        gap = gaps_on ? pick_gap() : 0;
        if (gap > 0) begin
            @(negedge i_clk) in_bus.valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        in_bus.valid       <= 1'b1;
        in_bus.motor_speed <= speed;
        @(posedge i_clk);
        while (!in_bus.ready) @(posedge i_clk);
        samples_sent++;
    endtask

    task automatic drain_results();
        @(negedge i_clk) in_bus.valid <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(t_cfg_reg idx, t_cfg_data value);
        @(negedge i_clk);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= idx;
        cfg_bus.data  <= value;
        @(posedge i_clk);
        while (!cfg_bus.ready) @(posedge i_clk);
        @(negedge i_clk) cfg_bus.valid <= 1'b0;
        if (idx == REG_SPEED_THRESHOLD) cur_threshold = int'(value[THR_BITS-1:0]);
        reg_writes++;
        settings_run++;
    endtask

    task automatic pick_settings();
        int         r;
        t_threshold thr;
        t_holdoff   hold;
        r = $urandom_range(0, 9);
        if (r == 0) thr = '0;
        else if (r == 1) thr = '1;
        else if (r < 5) thr = t_threshold'($urandom_range(1, 50));
        else if (r < 8) thr = t_threshold'($urandom_range(51, 2000));
        else thr = t_threshold'($urandom);
        r = $urandom_range(0, 9);
        if (r < 2) hold = '0;
        else if (r == 2) hold = '1;
        else if (r < 8) hold = t_holdoff'($urandom_range(1, 12));
        else hold = t_holdoff'($urandom);
        write_reg(REG_SPEED_THRESHOLD, {1'($urandom), thr});
        write_reg(REG_HOLDOFF_LIMIT, {8'($urandom), hold});
        if ($urandom_range(0, 3) == 0) begin
            write_reg(REG_SPARE_2, t_cfg_data'($urandom));
            write_reg(REG_SPARE_3, t_cfg_data'($urandom));
        end
    endtask

    task automatic run_settings(int n_items);
        int left;
        int run_len;
        int mode;
        int base;
        bit negative;
        left = n_items;
        while (left > 0) begin
            mode     = $urandom_range(0, 99);
            negative = 1'($urandom);
            run_len  = (mode < 40) ? $urandom_range(10, 25) : $urandom_range(1, 25);
            if (run_len > left) run_len = left;
            if (mode < 40) base = cur_threshold + $urandom_range(0, 4) - 2;
            else base = $urandom_range(0, 2 * cur_threshold + 50);
            if (negative) base = -base;
            for (int k = 0; k < run_len; k++) begin
                if (mode < 40) send_speed(clamp_speed(base));
                else if (mode < 65) send_speed(clamp_speed(base + $urandom_range(0, 40) - 20));
                else if (mode < 85) send_speed(t_sample'($urandom));
                else if (mode < 95) send_speed(clamp_speed(negative ? SPEED_MIN : SPEED_MAX));
                else send_speed('0);
            end
            left -= run_len;
            // hold off the sender until the output side is empty
            if ($urandom_range(0, 19) == 0) drain_results();
        end
    endtask

    initial begin
        out_bus.ready = 1'b0;
        forever begin
            int high_len;
            int low_len;
            int r;
            high_len = ($urandom_range(0, 6) == 0) ? $urandom_range(100, 300)
                                                   : $urandom_range(1, 40);
            r = $urandom_range(0, 99);
            if (r < 70) low_len = $urandom_range(1, 2);
            else if (r < 95) low_len = $urandom_range(3, 8);
            else low_len = $urandom_range(20, 60);
            @(negedge i_clk) out_bus.ready <= 1'b1;
            repeat (high_len - 1) @(negedge i_clk);
            @(negedge i_clk) out_bus.ready <= 1'b0;
            repeat (low_len - 1) @(negedge i_clk);
        end
    end

    initial begin
        #5000000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin
        int random_items;
        int phase_len;
        in_bus.valid       = 1'b0;
        in_bus.motor_speed = '0;
        cfg_bus.valid      = 1'b0;
        cfg_bus.index      = REG_SPEED_THRESHOLD;
        cfg_bus.data       = '0;
        i_rst_n            = 1'b0;
        samples_sent       = 0;
        reg_writes         = 0;
        settings_run       = 1;
        cur_threshold      = int'(THRESHOLD_RESET);
        gaps_on            = 1'b1;
        random_items       = 0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk) i_rst_n <= 1'b1;

        send_speed(t_sample'(SPEED_MAX));
        send_speed(t_sample'(SPEED_MIN));
        send_speed('0);
        send_speed(-16'sd1);
        drain_results();

        // zero threshold, no hold-off; spare indexes must not land anywhere
        write_reg(REG_SPEED_THRESHOLD, 16'h8000);
        write_reg(REG_HOLDOFF_LIMIT, 16'hFF00);
        write_reg(REG_SPARE_2, 16'hFFFF);
        write_reg(REG_SPARE_3, 16'h7FFF);
        repeat (5) send_speed(16'sd5);
        repeat (2) send_speed(-16'sd20);
        drain_results();

        write_reg(REG_SPEED_THRESHOLD, 16'h7FFF);
        write_reg(REG_HOLDOFF_LIMIT, 16'h00FF);
        repeat (3) send_speed(t_sample'(SPEED_MAX));
        drain_results();

        // fill the ring so the mean lands exactly on the threshold
        write_reg(REG_SPEED_THRESHOLD, 16'd100);
        write_reg(REG_HOLDOFF_LIMIT, 16'd0);
        repeat (10) send_speed(16'sd100);
        drain_results();

        // keep moving long enough for the hold-off count to saturate
        write_reg(REG_SPEED_THRESHOLD, 16'd5);
        write_reg(REG_HOLDOFF_LIMIT, 16'd255);
        repeat (280) send_speed(t_sample'($urandom_range(1000, SPEED_MAX)));
        random_items += 280;
        drain_results();

        while (random_items < 450) begin
            pick_settings();
            gaps_on   = ($urandom_range(0, 3) != 0);
            phase_len = $urandom_range(30, 90);
            run_settings(phase_len);
            random_items += phase_len;
            drain_results();
        end

        repeat (10) @(posedge i_clk);
        $display("%0d speed words over %0d register writes, spare indexes included",
                 samples_sent, reg_writes);
        $display("directions seen: %0d forward, %0d backward, %0d stopped",
                 fwd_count, bwd_count, stop_count);
        if (fail_count == 0 && pending == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

[filelist.f]
+incdir+design
design/madd_pkg.sv
design/madd_if.sv
design/moving_average_direction_detector.sv
design/madd_checker.sv
tb/madd_direction_checker.sv
tb/tb.sv
